// File: hdl/sme_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the stack machine executor.
// Used by the executor, the checker and the testbench; depends on nothing.
package sme_pkg;

    localparam int DATA_WORDS_DEF   = 512;
    localparam int LINE_ENTRIES_DEF = 256;
    localparam int VAR_COUNT        = 26;
    localparam int LINE_COUNT_W     = 9;
    localparam int PROG_LEN_W       = 16;

    // Opcodes (first instruction word)
    localparam logic [3:0] OP_LIT    = 4'd1;
    localparam logic [3:0] OP_OPR    = 4'd2;
    localparam logic [3:0] OP_LOAD   = 4'd3;
    localparam logic [3:0] OP_STORE  = 4'd4;
    localparam logic [3:0] OP_CALL   = 4'd5;
    localparam logic [3:0] OP_JUMP   = 4'd7;
    localparam logic [3:0] OP_BRZ    = 4'd8;
    localparam logic [3:0] OP_IO     = 4'd9;

    // Sub-ops of OP_OPR
    localparam logic [31:0] SUB_RET = 32'd0;
    localparam logic [31:0] SUB_ADD = 32'd1;
    localparam logic [31:0] SUB_SUB = 32'd2;
    localparam logic [31:0] SUB_MUL = 32'd3;
    localparam logic [31:0] SUB_DIV = 32'd4;
    localparam logic [31:0] SUB_EQ  = 32'd5;
    localparam logic [31:0] SUB_NE  = 32'd6;
    localparam logic [31:0] SUB_LT  = 32'd7;
    localparam logic [31:0] SUB_LE  = 32'd8;
    localparam logic [31:0] SUB_GT  = 32'd9;
    localparam logic [31:0] SUB_GE  = 32'd10;

    // Sub-ops of OP_IO
    localparam logic [3:0]  IO_STRING_LEVEL = 4'd1;
    localparam logic [31:0] IO_NEWLINE_KEY  = 32'hFFFF_FFFF;
    localparam logic [31:0] IO_PRINT        = 32'd1;
    localparam logic [31:0] IO_READ         = 32'd2;
    localparam logic [31:0] IO_HALT         = 32'd3;
    localparam logic [3:0]  JUMP_LEVEL      = 4'd1;

    // Events
    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_NUMBER  = 4'd1;
    localparam logic [3:0] EV_STRING  = 4'd2;
    localparam logic [3:0] EV_NEWLINE = 4'd3;
    localparam logic [3:0] EV_HALT    = 4'd4;
    localparam logic [3:0] EV_END     = 4'd5;
    localparam logic [3:0] EV_NO_LINE = 4'd6;
    localparam logic [3:0] EV_BAD_JMP = 4'd7;
    localparam logic [3:0] EV_DIV_0   = 4'd8;
    localparam logic [3:0] EV_STACK   = 4'd9;

    // Configuration register indexes
    localparam logic CFG_PROGRAM_LENGTH = 1'b0;
    localparam logic CFG_LINE_COUNT     = 1'b1;

    typedef struct packed {
        logic               func;
        logic [3:0]         opcode;
        logic [3:0]         level;
        logic signed [31:0] operand;
        logic signed [31:0] read_value;
        logic [7:0]         entry_index;
        logic [15:0]        line_number;
        logic [15:0]        line_target;
    } in_word_t;

    typedef struct packed {
        logic [15:0]        fetch_address;
        logic [3:0]         event_res;
        logic signed [31:0] event_value;
        logic               halted;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ_A,
        ST_READ_B,
        ST_EXEC,
        ST_DIV,
        ST_SEARCH,
        ST_WR2,
        ST_FIN
    } state_t;

endpackage

// File: hdl/stack_machine_executor.sv
`timescale 1ns / 1ps
// Stack machine executor: runs one p-code instruction per input word and
// returns one result word with the next fetch address. After reset the data
// store is cleared word by word before the first word is taken. Instructions
// that need stored data read both operands through the single read port of
// the data store RAM one after the other; divide waits for the bit-serial
// divider, and call or jump scan up to min(line_count,LINE_ENTRIES) entries
// of the line table RAM, with one more stack write for call. Line table writes
// and words for a stopped machine go straight to the result word.
// Depends on sme_pkg, sme_ram and sme_div.
module stack_machine_executor #(
    parameter int DATA_WORDS   = sme_pkg::DATA_WORDS_DEF,
    parameter int LINE_ENTRIES = sme_pkg::LINE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  sme_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sme_pkg::out_word_t m_data
);

    localparam int DA = $clog2(DATA_WORDS);
    localparam int SW = DA + 1;
    localparam int LA = (LINE_ENTRIES > 1) ? $clog2(LINE_ENTRIES) : 1;
    localparam int IW = (LA > sme_pkg::LINE_COUNT_W) ? LA : sme_pkg::LINE_COUNT_W;
    localparam logic [SW-1:0] DW_S   = SW'(DATA_WORDS);
    localparam logic [DA-1:0] LAST_A = DA'(DATA_WORDS - 1);

    sme_pkg::state_t    state_reg, state_next;
    logic [15:0]        pc_reg, pc_next;
    logic [SW-1:0]      sp_reg, sp_next;
    logic [SW-1:0]      fp_reg, fp_next;
    logic               stopped_reg, stopped_next;
    logic [15:0]        plen_reg;
    logic [8:0]         lcnt_reg;
    sme_pkg::in_word_t  in_reg, in_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [15:0]        tgt_reg, tgt_next;
    logic [DA-1:0]      clr_reg, clr_next;
    sme_pkg::out_word_t res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    sme_pkg::out_word_t m_data_reg, m_data_next;

    logic               ds_we;
    logic [DA-1:0]      ds_waddr, ds_raddr, addr_a, addr_b;
    logic [31:0]        ds_wdata, ds_rdata;
    logic               lt_we;
    logic [LA-1:0]      lt_waddr, lt_raddr;
    logic [31:0]        lt_wdata, lt_rdata;
    logic               div_start, div_done;
    logic [31:0]        div_q;

    logic [31:0]        opd;
    logic [15:0]        npc_inc;
    logic [IW-1:0]      n_lines;
    logic               is_ret;
    logic               fin;
    logic [3:0]         f_fault, f_ev;
    logic [31:0]        f_val;
    logic [15:0]        f_npc;
    logic [SW-1:0]      f_sp, f_fp;
    logic               f_halt;
    logic [31:0]        alu_out;
    logic [31:0]        prod;
    logic [SW:0]        sp_inc_w;

    sme_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data_ram (
        .aclk  (aclk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .raddr (ds_raddr),
        .rdata (ds_rdata)
    );

    sme_ram #(.WIDTH(32), .DEPTH(LINE_ENTRIES)) u_line_ram (
        .aclk  (aclk),
        .we    (lt_we),
        .waddr (lt_waddr),
        .wdata (lt_wdata),
        .raddr (lt_raddr),
        .rdata (lt_rdata)
    );

    sme_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (b_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sme_pkg::ST_CLEAR;
            pc_reg      <= '0;
            sp_reg      <= DW_S;
            fp_reg      <= DW_S;
            stopped_reg <= 1'b0;
            plen_reg    <= '0;
            lcnt_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            sp_reg      <= sp_next;
            fp_reg      <= fp_next;
            stopped_reg <= stopped_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sme_pkg::CFG_PROGRAM_LENGTH: plen_reg <= cfg_wr_data;
                    sme_pkg::CFG_LINE_COUNT:     lcnt_reg <= cfg_wr_data[8:0];
                    default: ;
                endcase
            end
        end
        in_reg     <= in_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        tgt_reg    <= tgt_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign opd      = $unsigned(in_reg.operand);
    assign npc_inc  = pc_reg + 16'd3;
    assign is_ret   = (in_reg.opcode == sme_pkg::OP_OPR) && (opd == sme_pkg::SUB_RET);
    assign sp_inc_w = {1'b0, sp_reg} + {{SW{1'b0}}, 1'b1};
    assign n_lines  = (32'(lcnt_reg) < LINE_ENTRIES) ? IW'(lcnt_reg) : IW'(LINE_ENTRIES);
    assign prod     = b_reg * a_reg;

    // Data store read addresses: first and second operand
    assign addr_a = is_ret ? fp_reg[DA-1:0] :
                    (in_reg.opcode == sme_pkg::OP_LOAD) ? opd[DA-1:0] : sp_reg[DA-1:0];
    assign addr_b = is_ret ? (fp_reg[DA-1:0] - DA'(1)) : (sp_reg[DA-1:0] + DA'(1));
    assign ds_raddr = (state_reg == sme_pkg::ST_READ_A) ? addr_b : addr_a;
    assign lt_raddr = idx_reg[LA-1:0];

    // Line table writes come straight off the input port
    assign lt_we    = s_valid && s_ready && s_data.func &&
                      (32'(s_data.entry_index) < LINE_ENTRIES);
    assign lt_waddr = LA'(s_data.entry_index);
    assign lt_wdata = {s_data.line_number, s_data.line_target};

    always_comb begin
        unique case (opd)
            sme_pkg::SUB_ADD: alu_out = b_reg + a_reg;
            sme_pkg::SUB_SUB: alu_out = b_reg - a_reg;
            sme_pkg::SUB_MUL: alu_out = prod;
            sme_pkg::SUB_EQ:  alu_out = 32'($signed(b_reg) == $signed(a_reg));
            sme_pkg::SUB_NE:  alu_out = 32'($signed(b_reg) != $signed(a_reg));
            sme_pkg::SUB_LT:  alu_out = 32'($signed(b_reg) <  $signed(a_reg));
            sme_pkg::SUB_LE:  alu_out = 32'($signed(b_reg) <= $signed(a_reg));
            sme_pkg::SUB_GT:  alu_out = 32'($signed(b_reg) >  $signed(a_reg));
            default:          alu_out = 32'($signed(b_reg) >= $signed(a_reg));
        endcase
    end

    assign s_ready = (state_reg == sme_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        sp_next      = sp_reg;
        fp_next      = fp_reg;
        stopped_next = stopped_reg;
        in_next      = in_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        tgt_next     = tgt_reg;
        clr_next     = clr_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ds_we        = 1'b0;
        ds_waddr     = sp_reg[DA-1:0] - DA'(1);
        ds_wdata     = '0;
        div_start    = 1'b0;
        fin          = 1'b0;
        f_fault      = sme_pkg::EV_NONE;
        f_ev         = sme_pkg::EV_NONE;
        f_val        = '0;
        f_npc        = npc_inc;
        f_sp         = sp_reg;
        f_fp         = fp_reg;
        f_halt       = 1'b0;

        unique case (state_reg)
            sme_pkg::ST_CLEAR: begin
                ds_we    = 1'b1;
                ds_waddr = clr_reg;
                ds_wdata = '0;
                clr_next = clr_reg + DA'(1);
                if (clr_reg == LAST_A) begin
                    state_next = sme_pkg::ST_IDLE;
                end
            end

            sme_pkg::ST_IDLE: begin
                if (s_valid) begin
                    in_next = s_data;
                    if (s_data.func || stopped_reg) begin
                        res_next   = '{fetch_address: pc_reg, event_res: sme_pkg::EV_NONE,
                                       event_value: '0, halted: stopped_reg};
                        state_next = sme_pkg::ST_FIN;
                    end else begin
                        state_next = sme_pkg::ST_DECODE;
                    end
                end
            end

            // Checks that need no stored data; start the operand reads
            sme_pkg::ST_DECODE: begin
                state_next = sme_pkg::ST_READ_A;
                unique case (in_reg.opcode)
                    sme_pkg::OP_LIT: begin
                        fin = 1'b1;
                        if (sp_reg == '0) begin
                            f_fault = sme_pkg::EV_STACK;
                        end else begin
                            ds_we    = 1'b1;
                            ds_wdata = opd;
                            f_sp     = sp_reg - SW'(1);
                        end
                    end
                    sme_pkg::OP_OPR: begin
                        if (opd == sme_pkg::SUB_RET) begin
                            if (fp_reg == '0 || fp_reg >= DW_S) begin
                                fin     = 1'b1;
                                f_fault = sme_pkg::EV_STACK;
                            end
                        end else if (opd <= sme_pkg::SUB_GE) begin
                            if (sp_inc_w >= {1'b0, DW_S}) begin
                                fin     = 1'b1;
                                f_fault = sme_pkg::EV_STACK;
                            end
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    sme_pkg::OP_LOAD: begin
                        if (opd >= 32'(sme_pkg::VAR_COUNT) || sp_reg == '0) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_STACK;
                        end
                    end
                    sme_pkg::OP_STORE: begin
                        if (opd >= 32'(sme_pkg::VAR_COUNT) || sp_reg >= DW_S) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_STACK;
                        end
                    end
                    sme_pkg::OP_CALL: begin
                        if (sp_reg == '0 || sp_reg >= DW_S) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_STACK;
                        end
                    end
                    sme_pkg::OP_JUMP: begin
                        if (in_reg.level != sme_pkg::JUMP_LEVEL) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_BAD_JMP;
                        end else if (sp_reg >= DW_S) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_STACK;
                        end
                    end
                    sme_pkg::OP_BRZ: begin
                        if (sp_reg >= DW_S) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_STACK;
                        end
                    end
                    sme_pkg::OP_IO: begin
                        if (in_reg.level == sme_pkg::IO_STRING_LEVEL) begin
                            fin = 1'b1;
                            if (opd == sme_pkg::IO_NEWLINE_KEY) begin
                                f_ev = sme_pkg::EV_NEWLINE;
                            end else begin
                                f_ev  = sme_pkg::EV_STRING;
                                f_val = opd;
                            end
                        end else if (opd == sme_pkg::IO_PRINT) begin
                            if (sp_reg >= DW_S) begin
                                fin     = 1'b1;
                                f_fault = sme_pkg::EV_STACK;
                            end
                        end else if (opd == sme_pkg::IO_READ) begin
                            fin = 1'b1;
                            if (sp_reg == '0) begin
                                f_fault = sme_pkg::EV_STACK;
                            end else begin
                                ds_we    = 1'b1;
                                ds_wdata = $unsigned(in_reg.read_value);
                                f_sp     = sp_reg - SW'(1);
                            end
                        end else if (opd == sme_pkg::IO_HALT) begin
                            fin    = 1'b1;
                            f_ev   = sme_pkg::EV_HALT;
                            f_halt = 1'b1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            sme_pkg::ST_READ_A: begin
                a_next     = ds_rdata;
                state_next = sme_pkg::ST_READ_B;
            end

            sme_pkg::ST_READ_B: begin
                b_next     = ds_rdata;
                state_next = sme_pkg::ST_EXEC;
            end

            sme_pkg::ST_EXEC: begin
                unique case (in_reg.opcode)
                    sme_pkg::OP_OPR: begin
                        if (is_ret) begin
                            fin = 1'b1;
                            if (a_reg > 32'(DATA_WORDS)) begin
                                f_fault = sme_pkg::EV_STACK;
                            end else begin
                                f_npc = b_reg[15:0];
                                f_sp  = fp_reg + SW'(1);
                                f_fp  = a_reg[SW-1:0];
                            end
                        end else if (opd == sme_pkg::SUB_DIV) begin
                            if (a_reg == '0) begin
                                fin     = 1'b1;
                                f_fault = sme_pkg::EV_DIV_0;
                            end else begin
                                div_start  = 1'b1;
                                state_next = sme_pkg::ST_DIV;
                            end
                        end else begin
                            fin      = 1'b1;
                            ds_we    = 1'b1;
                            ds_waddr = sp_inc_w[DA-1:0];
                            ds_wdata = alu_out;
                            f_sp     = sp_inc_w[SW-1:0];
                        end
                    end
                    sme_pkg::OP_LOAD: begin
                        fin      = 1'b1;
                        ds_we    = 1'b1;
                        ds_wdata = a_reg;
                        f_sp     = sp_reg - SW'(1);
                    end
                    sme_pkg::OP_STORE: begin
                        fin      = 1'b1;
                        ds_we    = 1'b1;
                        ds_waddr = opd[DA-1:0];
                        ds_wdata = a_reg;
                        f_sp     = sp_inc_w[SW-1:0];
                    end
                    sme_pkg::OP_CALL, sme_pkg::OP_JUMP: begin
                        if (a_reg > 32'h0000_FFFF) begin
                            fin     = 1'b1;
                            f_fault = sme_pkg::EV_NO_LINE;
                        end else begin
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = sme_pkg::ST_SEARCH;
                        end
                    end
                    sme_pkg::OP_BRZ: begin
                        fin  = 1'b1;
                        f_sp = sp_inc_w[SW-1:0];
                        if (a_reg == '0) begin
                            f_npc = opd[15:0];
                        end
                    end
                    sme_pkg::OP_IO: begin
                        fin   = 1'b1;
                        f_ev  = sme_pkg::EV_NUMBER;
                        f_val = a_reg;
                        f_sp  = sp_inc_w[SW-1:0];
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            sme_pkg::ST_DIV: begin
                if (div_done) begin
                    fin      = 1'b1;
                    ds_we    = 1'b1;
                    ds_waddr = sp_inc_w[DA-1:0];
                    ds_wdata = div_q;
                    f_sp     = sp_inc_w[SW-1:0];
                end
            end

            // Scan the line table; each read lands in the cycle after its address
            sme_pkg::ST_SEARCH: begin
                if (pend_reg && lt_rdata[31:16] == a_reg[15:0]) begin
                    if (in_reg.opcode == sme_pkg::OP_CALL) begin
                        ds_we      = 1'b1;
                        ds_waddr   = sp_reg[DA-1:0];
                        ds_wdata   = 32'(fp_reg);
                        tgt_next   = lt_rdata[15:0];
                        state_next = sme_pkg::ST_WR2;
                    end else begin
                        fin   = 1'b1;
                        f_npc = lt_rdata[15:0];
                        f_sp  = sp_inc_w[SW-1:0];
                    end
                end else if (idx_reg >= n_lines) begin
                    fin     = 1'b1;
                    f_fault = sme_pkg::EV_NO_LINE;
                end else begin
                    idx_next  = idx_reg + IW'(1);
                    pend_next = 1'b1;
                end
            end

            sme_pkg::ST_WR2: begin
                fin      = 1'b1;
                ds_we    = 1'b1;
                ds_wdata = 32'(npc_inc);
                f_npc    = tgt_reg;
                f_fp     = sp_reg;
                f_sp     = sp_reg - SW'(1);
            end

            sme_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = sme_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = sme_pkg::ST_IDLE;
            end
        endcase

        // Finish an instruction: commit it, or stop on a fault, and build its result word
        if (fin) begin
            state_next = sme_pkg::ST_FIN;
            if (f_fault != sme_pkg::EV_NONE) begin
                ds_we        = 1'b0;
                stopped_next = 1'b1;
                res_next     = '{fetch_address: pc_reg, event_res: f_fault,
                                 event_value: '0, halted: 1'b1};
            end else begin
                pc_next  = f_npc;
                sp_next  = f_sp;
                fp_next  = f_fp;
                res_next = '{fetch_address: f_npc, event_res: f_ev,
                             event_value: f_val, halted: 1'b0};
                if (f_halt) begin
                    stopped_next     = 1'b1;
                    res_next.halted  = 1'b1;
                end else if (f_npc >= plen_reg) begin
                    stopped_next    = 1'b1;
                    res_next.halted = 1'b1;
                    if (f_ev == sme_pkg::EV_NONE) begin
                        res_next.event_res = sme_pkg::EV_END;
                    end
                end
            end
        end
    end

endmodule

// File: hdl/sme_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/sme_div.sv
`timescale 1ns / 1ps
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// No dependencies; MIN / -1 wraps to MIN.
module sme_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (~dividend + 32'd1) : dividend;
            dvs_next  = divisor[31] ? (~divisor + 32'd1) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;

endmodule

// File: test/sme_checker.sv
`timescale 1ns / 1ps
// Checker for the stack machine executor: keeps its own copy of the machine
// state, predicts one result word per accepted input word and compares.
// Depends on sme_pkg only.
module sme_checker
    import sme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        errors,
    output int        pending
);

    localparam int DW = DATA_WORDS_DEF;
    localparam int LE = LINE_ENTRIES_DEF;

    logic [15:0] prog_len;
    logic [8:0]  line_cnt;
    logic [31:0] pc_q, sp_q, fp_q;
    logic [31:0] data_mem [DW];
    logic [31:0] line_mem [LE];
    logic        stopped_q;
    out_word_t   result_queue [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [31:0] alu(logic [31:0] sub, logic [31:0] a, logic [31:0] b);
        logic signed [31:0] sa, sb;
        sa = a;
        sb = b;
        case (sub)
            SUB_ADD: return a + b;
            SUB_SUB: return a - b;
            SUB_MUL: return a * b;
            SUB_DIV: begin
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
                return sa / sb;
            end
            SUB_EQ:  return 32'(sa == sb);
            SUB_NE:  return 32'(sa != sb);
            SUB_LT:  return 32'(sa < sb);
            SUB_LE:  return 32'(sa <= sb);
            SUB_GT:  return 32'(sa > sb);
            default: return 32'(sa >= sb);
        endcase
    endfunction

    // First matching slot among the searched ones
    function automatic bit lookup_line(logic [31:0] key, output logic [31:0] target);
        int n;
        n = (line_cnt < LE) ? int'(line_cnt) : LE;
        target = 0;
        if (key > 32'hFFFF) return 0;
        for (int i = 0; i < n; i++) begin
            if (line_mem[i][31:16] == key[15:0]) begin
                target = {16'h0, line_mem[i][15:0]};
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic out_word_t run_word(in_word_t w);
        logic [31:0] npc, sp, fp, opnd, val, tgt;
        logic [3:0]  ev, fault;
        bit          halt;
        out_word_t   r;
        opnd  = w.operand;
        npc   = (pc_q + 3) & 32'hFFFF;
        sp    = sp_q;
        fp    = fp_q;
        ev    = EV_NONE;
        fault = EV_NONE;
        val   = 0;
        halt  = 0;
        tgt   = 0;
        if (w.func) begin
            line_mem[w.entry_index] = {w.line_number, w.line_target};
        end else if (!stopped_q) begin
            case (w.opcode)
                OP_LIT: begin
                    if (sp == 0) fault = EV_STACK;
                    else begin sp--; data_mem[sp] = opnd; end
                end
                OP_OPR: begin
                    if (opnd == SUB_RET) begin
                        if (fp == 0 || fp >= DW) fault = EV_STACK;
                        else if (data_mem[fp] > DW) fault = EV_STACK;
                        else begin
                            npc = data_mem[fp - 1] & 32'hFFFF;
                            sp  = fp + 1;
                            fp  = data_mem[fp];
                        end
                    end else if (opnd <= SUB_GE) begin
                        if (sp + 1 >= DW) fault = EV_STACK;
                        else if (opnd == SUB_DIV && data_mem[sp] == 0) fault = EV_DIV_0;
                        else begin
                            data_mem[sp + 1] = alu(opnd, data_mem[sp + 1], data_mem[sp]);
                            sp++;
                        end
                    end
                end
                OP_LOAD: begin
                    if (opnd >= VAR_COUNT || sp == 0) fault = EV_STACK;
                    else begin sp--; data_mem[sp] = data_mem[opnd]; end
                end
                OP_STORE: begin
                    if (opnd >= VAR_COUNT || sp >= DW) fault = EV_STACK;
                    else begin data_mem[opnd] = data_mem[sp]; sp++; end
                end
                OP_CALL: begin
                    if (sp == 0 || sp >= DW) fault = EV_STACK;
                    else if (!lookup_line(data_mem[sp], tgt)) fault = EV_NO_LINE;
                    else begin
                        data_mem[sp]     = fp;
                        data_mem[sp - 1] = npc;
                        fp  = sp;
                        sp  = sp - 1;
                        npc = tgt;
                    end
                end
                OP_JUMP: begin
                    if (w.level != JUMP_LEVEL) fault = EV_BAD_JMP;
                    else if (sp >= DW) fault = EV_STACK;
                    else if (!lookup_line(data_mem[sp], tgt)) fault = EV_NO_LINE;
                    else begin npc = tgt; sp++; end
                end
                OP_BRZ: begin
                    if (sp >= DW) fault = EV_STACK;
                    else begin
                        if (data_mem[sp] == 0) npc = opnd & 32'hFFFF;
                        sp++;
                    end
                end
                OP_IO: begin
                    if (w.level == IO_STRING_LEVEL) begin
                        if (opnd == IO_NEWLINE_KEY) ev = EV_NEWLINE;
                        else begin ev = EV_STRING; val = opnd; end
                    end else if (opnd == IO_PRINT) begin
                        if (sp >= DW) fault = EV_STACK;
                        else begin ev = EV_NUMBER; val = data_mem[sp]; sp++; end
                    end else if (opnd == IO_READ) begin
                        if (sp == 0) fault = EV_STACK;
                        else begin sp--; data_mem[sp] = w.read_value; end
                    end else if (opnd == IO_HALT) begin
                        ev   = EV_HALT;
                        halt = 1;
                    end
                end
                default: ;
            endcase
            if (fault != EV_NONE) begin
                stopped_q = 1;
                ev  = fault;
                val = 0;
            end else begin
                pc_q = npc;
                sp_q = sp;
                fp_q = fp;
                if (halt) stopped_q = 1;
                else if (npc >= prog_len) begin
                    stopped_q = 1;
                    if (ev == EV_NONE) ev = EV_END;
                end
            end
        end
        r.fetch_address = pc_q[15:0];
        r.event_res     = ev;
        r.event_value   = val;
        r.halted        = stopped_q;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t exp_w;
        if (!aresetn) begin
            prog_len  <= 0;
            line_cnt  <= 0;
            pc_q      <= 0;
            sp_q      <= DW;
            fp_q      <= DW;
            stopped_q <= 0;
            for (int i = 0; i < DW; i++) data_mem[i] <= 0;
            for (int i = 0; i < LE; i++) line_mem[i] <= 0;
            result_queue.delete();
            pending <= 0;
        end else begin
            // compare before predicting: a word taken now cannot answer now
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    errors++;
                end else begin
                    exp_w = result_queue.pop_front();
                    if (m_data.fetch_address !== exp_w.fetch_address) begin
                        $display("%0t: fetch_address expected %0d got %0d", $time,
                                 exp_w.fetch_address, m_data.fetch_address);
                        errors++;
                    end
                    if (m_data.event_res !== exp_w.event_res) begin
                        $display("%0t: event_res expected %0d got %0d", $time,
                                 exp_w.event_res, m_data.event_res);
                        errors++;
                    end
                    if (m_data.event_value !== exp_w.event_value) begin
                        $display("%0t: event_value expected %0d got %0d", $time,
                                 exp_w.event_value, m_data.event_value);
                        errors++;
                    end
                    if (m_data.halted !== exp_w.halted) begin
                        $display("%0t: halted expected %0d got %0d", $time,
                                 exp_w.halted, m_data.halted);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_PROGRAM_LENGTH) prog_len = cfg_wr_data;
                else line_cnt = cfg_wr_data[8:0];
            end
            if (s_valid && s_ready) result_queue.push_back(run_word(s_data));
            pending <= result_queue.size();
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the stack machine executor test: drives random programs, stray
// opcodes included, with backpressure and gives the verdict. Depends on
// sme_pkg, the block and sme_checker.
module testbench;
    import sme_pkg::*;

    logic      aclk        = 0;
    logic      aresetn     = 0;
    logic      cfg_wr_en   = 0;
    logic      cfg_index   = 0;
    logic [15:0] cfg_wr_data = 0;
    logic      s_valid     = 0;
    logic      s_ready;
    in_word_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 0;
    out_word_t m_data;
    int        errors, pending;

    int          tx_pct = 0, rx_pct = 0;
    int          depth = 0, floor_d = 0, lc_cur = 0;
    int          call_depth_q [$];
    int          call_floor_q [$];
    logic [15:0] line_shadow [256];
    bit          flow_ok = 0;
    logic [15:0] tgt_cap = 16'd30000;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    stack_machine_executor DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    sme_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    always @(posedge aclk) m_ready <= ($urandom_range(0, 99) >= rx_pct);

    function automatic in_word_t rnd_word();
        in_word_t w;
        w = {$urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic logic [3:0] lvl_not1();
        logic [3:0] v;
        v = $urandom_range(0, 14);
        if (v >= 1) v++;
        return v;
    endfunction

    task automatic send(in_word_t w);
        while ($urandom_range(0, 99) < tx_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic cfg_write(logic idx, logic [15:0] v);
        cfg_index   <= idx;
        cfg_wr_data <= v;
        cfg_wr_en   <= 1;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic put(logic [3:0] op, logic [3:0] lvl, logic [31:0] opnd, int dd);
        in_word_t w;
        w = rnd_word();
        w.func    = 0;
        w.opcode  = op;
        w.level   = lvl;
        w.operand = opnd;
        send(w);
        depth += dd;
    endtask

    task automatic line_write(logic [7:0] idx, logic [15:0] ln, logic [15:0] lt);
        in_word_t w;
        w = rnd_word();
        w.func        = 1;
        w.entry_index = idx;
        w.line_number = ln;
        w.line_target = lt;
        send(w);
        line_shadow[idx] = ln;
    endtask

    task automatic random_instr();
        int k, avail;
        logic [3:0] uop;
        avail = depth - floor_d;
        k = $urandom_range(0, 99);
        if (k >= 92 && k < 100) begin
            if (flow_ok) line_write($urandom, $urandom, $urandom_range(0, tgt_cap));
            else line_write($urandom, $urandom, $urandom);
        end else if (k >= 88 && call_depth_q.size() != 0) begin
            // return: the frame's locals vanish
            put(OP_OPR, $urandom, SUB_RET, 0);
            depth   = call_depth_q.pop_back() - 1;
            floor_d = call_floor_q.pop_back();
        end else if (k >= 76 && k < 84 && flow_ok && call_depth_q.size() < 20 && depth < 280) begin
            put(OP_LIT, $urandom, {16'h0, line_shadow[$urandom_range(0, lc_cur - 1)]}, 1);
            call_depth_q.push_back(depth);
            call_floor_q.push_back(floor_d);
            put(OP_CALL, $urandom, $urandom, 1);
            floor_d = depth;
        end else if (k >= 84 && k < 88 && flow_ok && depth < 290) begin
            put(OP_LIT, $urandom, {16'h0, line_shadow[$urandom_range(0, lc_cur - 1)]}, 1);
            put(OP_JUMP, JUMP_LEVEL, $urandom, -1);
        end else if (k >= 72 && k < 76) begin
            uop = $urandom_range(0, 7);
            case (uop)
                0: put(4'd0, $urandom, $urandom, 0);
                1: put(4'd6, $urandom, $urandom, 0);
                2: put(OP_OPR, $urandom, $urandom_range(11, 32'hFFFF_FFFF), 0);
                3: put(OP_IO, lvl_not1(), $urandom_range(4, 32'hFFFF_FFFF), 0);
                4: put(OP_IO, lvl_not1(), 32'd0, 0);
                default: put(4'($urandom_range(10, 15)), $urandom, $urandom, 0);
            endcase
        end else if (k >= 67 && k < 72) begin
            put(OP_IO, IO_STRING_LEVEL, ($urandom_range(0, 9) == 0) ? IO_NEWLINE_KEY : $urandom, 0);
        end else if (depth >= 280) begin
            if (avail >= 1) put(OP_STORE, $urandom, $urandom_range(0, VAR_COUNT - 1), -1);
            else begin
                put(OP_OPR, $urandom, SUB_RET, 0);
                depth   = call_depth_q.pop_back() - 1;
                floor_d = call_floor_q.pop_back();
            end
        end else if (k < 12 || avail < 1) begin
            if (k % 3 == 0) put(OP_LOAD, $urandom, $urandom_range(0, VAR_COUNT - 1), 1);
            else if (k % 3 == 1) begin
                in_word_t w;
                w = rnd_word();
                w.func = 0; w.opcode = OP_IO; w.level = lvl_not1(); w.operand = IO_READ;
                send(w);
                depth++;
            end else put(OP_LIT, $urandom, $urandom, 1);
        end else if (k < 20) begin
            put(OP_LOAD, $urandom, $urandom_range(0, VAR_COUNT - 1), 1);
        end else if (k < 28) begin
            put(OP_STORE, $urandom, $urandom_range(0, VAR_COUNT - 1), -1);
        end else if (k < 45 && avail >= 2) begin
            uop = $urandom_range(0, 8);
            put(OP_OPR, $urandom, (uop < 3) ? 32'(uop + 1) : 32'(uop + 2), -1);
        end else if (k < 50) begin
            // nonzero divisor keeps the machine running
            put(OP_LIT, $urandom, ($urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom | 1), 1);
            put(OP_OPR, $urandom, SUB_DIV, -1);
        end else if (k < 56) begin
            put(OP_BRZ, $urandom, {16'($urandom), 16'($urandom_range(0, tgt_cap))}, -1);
        end else if (k < 62) begin
            put(OP_IO, lvl_not1(), IO_PRINT, -1);
        end else begin
            put(OP_LIT, $urandom, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, 1);
        end
    endtask

    initial begin
        int kind;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // phase one: sender rarely idles, receiver mostly stalls
        tx_pct = 9;
        rx_pct = 66;
        cfg_write(CFG_PROGRAM_LENGTH, 16'hFFFF);
        cfg_write(CFG_LINE_COUNT, 16'd256);
        lc_cur = 256;
        for (int i = 0; i < 256; i++) line_write(i, $urandom, $urandom_range(0, tgt_cap));

        // arithmetic edges: wrap, MIN / -1, compares, io
        put(OP_LIT, 0, 32'h7FFF_FFFF, 1);
        put(OP_LIT, 0, 32'd1, 1);
        put(OP_OPR, 0, SUB_ADD, -1);
        put(OP_LIT, 0, 32'hFFFF_FFFF, 1);
        put(OP_OPR, 0, SUB_DIV, -1);
        put(OP_LIT, 0, 32'h8000_0000, 1);
        put(OP_OPR, 0, SUB_MUL, -1);
        put(OP_LIT, 15, -32'sd5, 1);
        put(OP_OPR, 0, SUB_SUB, -1);
        for (int s = 5; s <= 10; s++) begin
            put(OP_LIT, 0, 32'($urandom_range(0, 2)) - 32'd1, 1);
            put(OP_OPR, 0, 32'(s), -1);
        end
        put(OP_IO, 0, IO_PRINT, -1);
        put(OP_IO, IO_STRING_LEVEL, IO_NEWLINE_KEY, 0);
        put(OP_IO, IO_STRING_LEVEL, 32'h8000_0000, 0);

        flow_ok = 1;
        repeat (600) random_instr();
        drain();

        // phase two: roles swapped, shorter table and program
        tx_pct = 66;
        rx_pct = 9;
        lc_cur = $urandom_range(1, 255);
        cfg_write(CFG_LINE_COUNT, 16'(lc_cur));
        cfg_write(CFG_PROGRAM_LENGTH, 16'd60000);
        repeat (600) random_instr();
        drain();

        // phase three: no idling, empty table so no call or jump
        tx_pct = 0;
        rx_pct = 0;
        flow_ok = 0;
        cfg_write(CFG_LINE_COUNT, 16'd0);
        cfg_write(CFG_PROGRAM_LENGTH, 16'hFFFF);
        repeat (450) random_instr();

        // end the program one way or another
        kind = $urandom_range(0, 5);
        case (kind)
            0: begin
                put(OP_LIT, 0, 32'd5, 1);
                put(OP_LIT, 0, 32'd0, 1);
                put(OP_OPR, 0, SUB_DIV, -1);
            end
            1: begin
                put(OP_LIT, 0, 32'h0001_0000, 1);
                put(OP_JUMP, JUMP_LEVEL, 32'd0, 0);
            end
            2: put(OP_JUMP, 4'd0, 32'd0, 0);
            3: put(OP_LOAD, 0, VAR_COUNT, 0);
            4: put(OP_IO, 4'd0, IO_HALT, 0);
            default: begin
                put(OP_LIT, 0, 32'd0, 1);
                put(OP_BRZ, 0, 32'h0000_FFFF, -1);
            end
        endcase
        repeat (10) send(rnd_word());
        drain();
        cfg_write(CFG_PROGRAM_LENGTH, 16'd0);
        cfg_write(CFG_LINE_COUNT, 16'd256);
        repeat (5) send(rnd_word());
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: stack_machine_executor.f
hdl/sme_pkg.sv
hdl/sme_ram.sv
hdl/sme_div.sv
hdl/stack_machine_executor.sv
test/sme_checker.sv
test/testbench.sv
